// File: src/sdspi_pkg.sv
// Shared types and constants for the SD card SPI host command engine.
package sdspi_pkg;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_LINK  = 2'd3;

    localparam logic [1:0] CFG_POLL  = 2'd0;
    localparam logic [1:0] CFG_RETRY = 2'd1;
    localparam logic [1:0] CFG_TOKEN = 2'd2;
    localparam logic [1:0] CFG_BUSY  = 2'd3;

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_C0_TX    = 5'd1;
    localparam logic [4:0] PH_C0_POLL  = 5'd2;
    localparam logic [4:0] PH_C8_TX    = 5'd3;
    localparam logic [4:0] PH_C8_POLL  = 5'd4;
    localparam logic [4:0] PH_C8_TAIL  = 5'd5;
    localparam logic [4:0] PH_C55_TX   = 5'd6;
    localparam logic [4:0] PH_C55_POLL = 5'd7;
    localparam logic [4:0] PH_C41_TX   = 5'd8;
    localparam logic [4:0] PH_C41_POLL = 5'd9;
    localparam logic [4:0] PH_C58_TX   = 5'd10;
    localparam logic [4:0] PH_C58_POLL = 5'd11;
    localparam logic [4:0] PH_C58_TAIL = 5'd12;
    localparam logic [4:0] PH_C17_TX   = 5'd13;
    localparam logic [4:0] PH_C17_POLL = 5'd14;
    localparam logic [4:0] PH_RD_TOKEN = 5'd15;
    localparam logic [4:0] PH_RD_DATA  = 5'd16;
    localparam logic [4:0] PH_RD_CRC   = 5'd17;
    localparam logic [4:0] PH_C24_TX   = 5'd18;
    localparam logic [4:0] PH_C24_POLL = 5'd19;
    localparam logic [4:0] PH_WR_GAP   = 5'd20;
    localparam logic [4:0] PH_WR_TOKEN = 5'd21;
    localparam logic [4:0] PH_WR_DATA  = 5'd22;
    localparam logic [4:0] PH_WR_CRC   = 5'd23;
    localparam logic [4:0] PH_WR_RESP  = 5'd24;
    localparam logic [4:0] PH_WR_BUSY  = 5'd25;

    localparam logic [7:0]  CMD_START  = 8'h40;
    localparam logic [7:0]  RESP_BUSY  = 8'h80;
    localparam logic [7:0]  CRC_CMD0   = 8'h95;
    localparam logic [7:0]  CRC_CMD8   = 8'h87;
    localparam logic [7:0]  CRC_NONE   = 8'h01;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
    localparam logic [7:0]  ECHO_AA    = 8'hAA;
    localparam logic [7:0]  DATA_TOKEN = 8'hFE;
    localparam logic [7:0]  DRESP_MASK = 8'h1F;
    localparam logic [7:0]  DRESP_OK   = 8'h05;
    localparam logic [7:0]  FILLER     = 8'hFF;
    localparam logic [7:0]  R1_IDLE    = 8'h01;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] sector;
        logic [7:0]  rx;
        logic [7:0]  wd;
    } t_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       need;
        logic       done;
        logic       status;
    } t_result;

    typedef struct packed {
        logic [7:0]  poll;
        logic [15:0] retry;
        logic [15:0] token;
        logic [19:0] busy;
    } t_limits;

endpackage

// File: src/sd_spi_host_command_engine_top.sv
// Top level of the SD card SPI-mode host command engine.
// One item per link byte: a request item (init, sector read, sector write)
// starts an operation, and each link item reports the byte the card returned
// and gets back the next byte to send, chip select, any read byte and, at the
// end, done with ok/error. The front stage takes items into a two-entry queue;
// the sequencer retires one queued item per cycle into an output register, so
// with the output side not stalling an item is accepted every cycle; a result
// passes the queue, then the output register. Limits must be written through
// the config port while idle (not enforced here); a zero limit behaves as one.
module sd_spi_host_command_engine_top #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_sector,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_chip_select,
    output logic [7:0]  o_rd_data,
    output logic        o_rd_valid,
    output logic        o_need_write_data,
    output logic        o_done_res,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import sdspi_pkg::*;

    t_limits r_lim;
    t_item   in_item, q_item;
    t_result res;
    logic    q_full, q_valid, pop, push;

    assign o_stall     = q_full;
    assign push        = i_valid && !q_full;
    assign o_cfg_ready = 1'b1;
    assign in_item     = '{req: i_req_type, sector: i_sector, rx: i_rx_byte,
                           wd: i_write_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '{poll: 8'd100, retry: 16'd10000, token: 16'hFFFF, busy: 20'hFFFFF};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLL:  r_lim.poll  <= i_cfg_data[7:0];
                CFG_RETRY: r_lim.retry <= i_cfg_data[15:0];
                CFG_TOKEN: r_lim.token <= i_cfg_data[15:0];
                default:   r_lim.busy  <= i_cfg_data;
            endcase
        end
    end

    sdspi_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(in_item),
        .o_full(q_full), .i_pop(pop), .o_valid(q_valid), .o_item(q_item)
    );

    sdspi_back #(.SECTOR_BYTES(SECTOR_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_pop(pop), .i_lim(r_lim), .o_valid(o_valid), .o_res(res), .i_stall(i_stall)
    );

    assign o_tx_byte         = res.tx_byte;
    assign o_tx_valid        = res.tx_valid;
    assign o_chip_select     = res.tx_valid;
    assign o_rd_data         = res.rd_data;
    assign o_rd_valid        = res.rd_valid;
    assign o_need_write_data = res.need;
    assign o_done_res        = res.done;
    assign o_status          = res.status;

    // a result never asks for a byte and reports the end together
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_tx_valid)) else $error("done with tx");
    // write data is only requested while an exchange is requested
    a_need_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_need_write_data |-> o_tx_valid) else $error("need without tx");
    // status only meaningful at done
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_done_res) else $error("status without done");
endmodule

// File: src/sdspi_queue.sv
// Two-entry item queue between the front and the back of the engine.
module sdspi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sdspi_pkg::t_item   i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output sdspi_pkg::t_item   o_item
);
    import sdspi_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: src/sdspi_back.sv
// Command sequencer: carries out one item per cycle while its output is not stalled, and holds the result register.
module sdspi_back #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sdspi_pkg::t_item   i_item,
    output logic               o_pop,
    input  sdspi_pkg::t_limits i_lim,
    output logic               o_valid,
    output sdspi_pkg::t_result o_res,
    input  logic               i_stall
);
    import sdspi_pkg::*;

    localparam int BW = $clog2(SECTOR_BYTES + 1);

    logic [4:0]  r_phase, n_phase;
    logic [BW-1:0] r_idx, n_idx;
    logic [19:0] r_poll, n_poll;
    logic [15:0] r_retry, n_retry;
    logic [31:0] r_arg, n_arg;
    logic [7:0]  r_last, n_last;
    logic        r_ov;
    t_result     r_res, n_res;
    logic        go;

    logic [7:0]  lp;
    logic [15:0] lr, lt;
    logic [19:0] lb;

    assign lp = (i_lim.poll  == 8'd0)  ? 8'd1  : i_lim.poll;
    assign lr = (i_lim.retry == 16'd0) ? 16'd1 : i_lim.retry;
    assign lt = (i_lim.token == 16'd0) ? 16'd1 : i_lim.token;
    assign lb = (i_lim.busy  == 20'd0) ? 20'd1 : i_lim.busy;

    assign go      = i_valid && (!r_ov || !i_stall);
    assign o_pop   = go;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    function automatic logic [7:0] frame(input logic [4:0] ph, input logic [2:0] k,
                                         input logic [31:0] arg);
        logic [7:0] cmd, crc;
        crc = CRC_NONE;
        unique case (ph)
            PH_C0_TX:  begin cmd = 8'd0; crc = CRC_CMD0; end
            PH_C8_TX:  begin cmd = 8'd8; crc = CRC_CMD8; end
            PH_C55_TX: cmd = 8'd55;
            PH_C41_TX: cmd = 8'd41;
            PH_C58_TX: cmd = 8'd58;
            PH_C17_TX: cmd = 8'd17;
            default:   cmd = 8'd24;
        endcase
        case (k)
            3'd0:    frame = CMD_START | cmd;
            3'd1:    frame = arg[31:24];
            3'd2:    frame = arg[23:16];
            3'd3:    frame = arg[15:8];
            3'd4:    frame = arg[7:0];
            default: frame = crc;
        endcase
    endfunction

    always_comb begin
        logic [7:0] rx, r;
        logic resp, fin, ferr, startc;
        logic [4:0] sph;
        logic [31:0] sarg;
        rx = i_item.rx;
        n_phase = r_phase; n_idx = r_idx; n_poll = r_poll; n_retry = r_retry;
        n_arg = r_arg; n_last = r_last;
        n_res = '0;
        resp = 1'b0; r = rx; fin = 1'b0; ferr = 1'b0;
        startc = 1'b0; sph = PH_C0_TX; sarg = '0;
        unique case (i_item.req)
            REQ_INIT:  begin startc = 1'b1; sph = PH_C0_TX; end
            REQ_READ:  begin startc = 1'b1; sph = PH_C17_TX; sarg = i_item.sector; end
            REQ_WRITE: begin startc = 1'b1; sph = PH_C24_TX; sarg = i_item.sector; end
            default: begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_C0_TX, PH_C8_TX, PH_C55_TX, PH_C41_TX, PH_C58_TX,
                    PH_C17_TX, PH_C24_TX: begin
                        n_idx = r_idx + 1'b1;
                        if (r_idx < BW'(5)) begin
                            n_res.tx_byte = frame(r_phase, 3'(r_idx + 1'b1), r_arg);
                            n_res.tx_valid = 1'b1;
                        end else begin
                            n_phase = r_phase + 5'd1; n_poll = 20'd1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end
                    end
                    PH_C0_POLL, PH_C8_POLL, PH_C55_POLL, PH_C41_POLL, PH_C58_POLL,
                    PH_C17_POLL, PH_C24_POLL: begin
                        if ((rx & RESP_BUSY) == 8'd0) resp = 1'b1;
                        else if (r_poll >= {12'd0, lp}) begin resp = 1'b1; r = FILLER; end
                        else begin
                            n_poll = r_poll + 20'd1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end
                    end
                    PH_C8_TAIL: begin
                        if (r_idx == BW'(2) && rx != R1_IDLE) n_last = FILLER;
                        if (r_idx < BW'(3)) begin
                            n_idx = r_idx + 1'b1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end else if (r_last != R1_IDLE || rx != ECHO_AA) begin
                            fin = 1'b1; ferr = 1'b1;
                        end else begin
                            n_retry = '0; startc = 1'b1; sph = PH_C55_TX;
                        end
                    end
                    PH_C58_TAIL: begin
                        if (r_idx < BW'(3)) begin
                            n_idx = r_idx + 1'b1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end else begin fin = 1'b1; ferr = (r_last != 8'd0); end
                    end
                    PH_RD_TOKEN: begin
                        if (rx == DATA_TOKEN) begin
                            n_phase = PH_RD_DATA; n_idx = '0;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end else if (r_poll >= {4'd0, lt}) begin fin = 1'b1; ferr = 1'b1; end
                        else begin
                            n_poll = r_poll + 20'd1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end
                    end
                    PH_RD_DATA: begin
                        n_res.rd_data = rx; n_res.rd_valid = 1'b1;
                        n_idx = r_idx + 1'b1;
                        if (r_idx + 1'b1 >= BW'(SECTOR_BYTES)) begin
                            n_phase = PH_RD_CRC; n_idx = '0;
                        end
                        n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                    end
                    PH_RD_CRC: begin
                        if (r_idx == '0) begin
                            n_idx = BW'(1); n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end else fin = 1'b1;
                    end
                    PH_WR_GAP: begin
                        n_phase = PH_WR_TOKEN; n_res.need = 1'b1;
                        n_res.tx_byte = DATA_TOKEN; n_res.tx_valid = 1'b1;
                    end
                    PH_WR_TOKEN, PH_WR_DATA: begin
                        logic [BW-1:0] bi;
                        bi = (r_phase == PH_WR_TOKEN) ? '0 : r_idx;
                        n_phase = PH_WR_DATA;
                        n_res.tx_valid = 1'b1;
                        if (bi < BW'(SECTOR_BYTES)) begin
                            n_res.tx_byte = i_item.wd;
                            n_idx = bi + 1'b1;
                            n_res.need = (bi + 1'b1) < BW'(SECTOR_BYTES);
                        end else begin
                            n_phase = PH_WR_CRC; n_idx = '0; n_res.tx_byte = FILLER;
                        end
                    end
                    PH_WR_CRC: begin
                        if (r_idx == '0) n_idx = BW'(1); else n_phase = PH_WR_RESP;
                        n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                    end
                    PH_WR_RESP: begin
                        if ((rx & DRESP_MASK) != DRESP_OK) begin fin = 1'b1; ferr = 1'b1; end
                        else begin
                            n_phase = PH_WR_BUSY; n_poll = 20'd1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end
                    end
                    PH_WR_BUSY: begin
                        if (rx != 8'd0) fin = 1'b1;
                        else if (r_poll >= lb) begin fin = 1'b1; ferr = 1'b1; end
                        else begin
                            n_poll = r_poll + 20'd1;
                            n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        endcase
        if (resp) begin
            n_last = r;
            unique case (r_phase)
                PH_C0_POLL: begin
                    if (r != R1_IDLE) begin fin = 1'b1; ferr = 1'b1; end
                    else begin startc = 1'b1; sph = PH_C8_TX; sarg = ARG_CMD8; end
                end
                PH_C8_POLL, PH_C58_POLL: begin
                    n_phase = r_phase + 5'd1; n_idx = '0;
                    n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                end
                PH_C55_POLL: begin
                    if (r > R1_IDLE) begin fin = 1'b1; ferr = 1'b1; end
                    else begin startc = 1'b1; sph = PH_C41_TX; sarg = ARG_ACMD41; end
                end
                PH_C41_POLL: begin
                    n_retry = r_retry + 16'd1;
                    if (r == 8'd0) begin startc = 1'b1; sph = PH_C58_TX; end
                    else if (r_retry + 16'd1 >= lr) begin fin = 1'b1; ferr = 1'b1; end
                    else begin startc = 1'b1; sph = PH_C55_TX; end
                end
                PH_C17_POLL: begin
                    if (r != 8'd0) begin fin = 1'b1; ferr = 1'b1; end
                    else begin
                        n_phase = PH_RD_TOKEN; n_poll = 20'd1;
                        n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                    end
                end
                default: begin
                    if (r != 8'd0) begin fin = 1'b1; ferr = 1'b1; end
                    else begin
                        n_phase = PH_WR_GAP;
                        n_res.tx_byte = FILLER; n_res.tx_valid = 1'b1;
                    end
                end
            endcase
        end
        if (startc) begin
            n_phase = sph; n_idx = '0; n_arg = sarg;
            n_res.tx_byte = frame(sph, 3'd0, sarg); n_res.tx_valid = 1'b1;
        end
        if (fin) begin
            n_phase = PH_IDLE;
            n_res.tx_byte = '0; n_res.tx_valid = 1'b0; n_res.need = 1'b0;
            n_res.done = 1'b1; n_res.status = ferr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_idx <= '0; r_poll <= '0; r_retry <= '0;
            r_arg <= '0; r_last <= '0; r_ov <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase; r_idx <= n_idx; r_poll <= n_poll;
                r_retry <= n_retry; r_arg <= n_arg; r_last <= n_last;
            end
            if (go) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end
endmodule

// File: test/tb.sv
// Self-checking testbench for the SD card SPI-mode host command engine.
`timescale 1ns / 1ps

module tb;
    import sdspi_pkg::*;

    localparam int SECTOR_BYTES = 512;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEMS_PER_PH = 385;

    // command indexes as they appear in the first frame byte
    localparam logic [7:0] CMD_GO_IDLE   = 8'd0;
    localparam logic [7:0] CMD_IF_COND   = 8'd8;
    localparam logic [7:0] CMD_APP       = 8'd55;
    localparam logic [7:0] CMD_OP_COND   = 8'd41;
    localparam logic [7:0] CMD_READ_OCR  = 8'd58;
    localparam logic [7:0] CMD_READ_SECT = 8'd17;
    localparam logic [7:0] CMD_WRITE_SEC = 8'd24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = REQ_LINK;
    logic [31:0] i_sector = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_tx_valid;
    logic        o_chip_select;
    logic [7:0]  o_rd_data;
    logic        o_rd_valid;
    logic        o_need_write_data;
    logic        o_done_res;
    logic        o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_POLL;
    logic [19:0] i_cfg_data = '0;

    sd_spi_host_command_engine_top #(.SECTOR_BYTES(SECTOR_BYTES)) dut (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Engine mirror: limits and sequencer state tracked in the bench
    // ------------------------------------------------------------------
    logic [7:0]  lim_poll;
    logic [15:0] lim_retry;
    logic [15:0] lim_token;
    logic [19:0] lim_busy;
    logic [4:0]  eng_phase;
    logic [9:0]  eng_idx;
    logic [19:0] eng_poll;
    logic [15:0] eng_retry;
    logic [31:0] eng_arg;
    logic [7:0]  eng_last;
    t_result     nxt;

    t_result     expected_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          snd_idle_pct = 28;
    int          rcv_idle_pct = 75;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // A zero limit behaves as one.
    function automatic logic [19:0] lim_eff(input logic [19:0] v);
        return (v == '0) ? 20'd1 : v;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [4:0] p, input logic [9:0] k);
        logic [7:0] cmd;
        logic [7:0] crc;
        crc = CRC_NONE;
        case (p)
            PH_C0_TX: begin
                cmd = CMD_GO_IDLE;
                crc = CRC_CMD0;
            end
            PH_C8_TX: begin
                cmd = CMD_IF_COND;
                crc = CRC_CMD8;
            end
            PH_C55_TX: cmd = CMD_APP;
            PH_C41_TX: cmd = CMD_OP_COND;
            PH_C58_TX: cmd = CMD_READ_OCR;
            PH_C17_TX: cmd = CMD_READ_SECT;
            default:   cmd = CMD_WRITE_SEC;
        endcase
        if (k == 0) return CMD_START | cmd;
        if (k >= 5) return crc;
        return 8'(eng_arg >> (8 * (4 - k)));
    endfunction

    task automatic tx(input logic [7:0] b);
        nxt.tx_byte  = b;
        nxt.tx_valid = 1'b1;
    endtask

    task automatic end_op(input logic err);
        eng_phase    = PH_IDLE;
        nxt.tx_valid = 1'b0;
        nxt.tx_byte  = '0;
        nxt.need     = 1'b0;
        nxt.done     = 1'b1;
        nxt.status   = err;
    endtask

    task automatic start_cmd(input logic [4:0] p, input logic [31:0] arg);
        eng_phase = p;
        eng_idx   = '0;
        eng_arg   = arg;
        tx(frame_byte(p, 10'd0));
    endtask

    task automatic take_response(input logic [7:0] r);
        eng_last = r;
        case (eng_phase)
            PH_C0_POLL:
                if (r != R1_IDLE) end_op(1'b1);
                else start_cmd(PH_C8_TX, ARG_CMD8);
            PH_C8_POLL, PH_C58_POLL: begin
                eng_phase = eng_phase + 5'd1;
                eng_idx   = '0;
                tx(FILLER);
            end
            PH_C55_POLL:
                if (r > R1_IDLE) end_op(1'b1);
                else start_cmd(PH_C41_TX, ARG_ACMD41);
            PH_C41_POLL: begin
                eng_retry = eng_retry + 16'd1;
                if (r == 8'h00) start_cmd(PH_C58_TX, 32'd0);
                else if (20'(eng_retry) >= lim_eff(20'(lim_retry))) end_op(1'b1);
                else start_cmd(PH_C55_TX, 32'd0);
            end
            PH_C17_POLL:
                if (r != 8'h00) end_op(1'b1);
                else begin
                    eng_phase = PH_RD_TOKEN;
                    eng_poll  = 20'd1;
                    tx(FILLER);
                end
            default:
                if (r != 8'h00) end_op(1'b1);
                else begin
                    eng_phase = PH_WR_GAP;
                    tx(FILLER);
                end
        endcase
    endtask

    task automatic sector_out(input logic [7:0] wd);
        eng_phase = PH_WR_DATA;
        if (eng_idx < SECTOR_BYTES) begin
            tx(wd);
            eng_idx  = eng_idx + 10'd1;
            nxt.need = (eng_idx < SECTOR_BYTES);
        end else begin
            eng_phase = PH_WR_CRC;
            eng_idx   = '0;
            tx(FILLER);
        end
    endtask

    task automatic link_byte(input logic [7:0] rx, input logic [7:0] wd);
        case (eng_phase)
            PH_C0_TX, PH_C8_TX, PH_C55_TX, PH_C41_TX, PH_C58_TX, PH_C17_TX, PH_C24_TX: begin
                eng_idx = eng_idx + 10'd1;
                if (eng_idx < 6) tx(frame_byte(eng_phase, eng_idx));
                else begin
                    eng_phase = eng_phase + 5'd1;
                    eng_poll  = 20'd1;
                    tx(FILLER);
                end
            end
            PH_C0_POLL, PH_C8_POLL, PH_C55_POLL, PH_C41_POLL, PH_C58_POLL, PH_C17_POLL,
            PH_C24_POLL:
                if ((rx & RESP_BUSY) == 8'h00) take_response(rx);
                else if (eng_poll >= lim_eff(20'(lim_poll))) take_response(FILLER);
                else begin
                    eng_poll = eng_poll + 20'd1;
                    tx(FILLER);
                end
            PH_C8_TAIL: begin
                if (eng_idx == 2 && rx != R1_IDLE) eng_last = FILLER;
                if (eng_idx < 3) begin
                    eng_idx = eng_idx + 10'd1;
                    tx(FILLER);
                end else if (eng_last != R1_IDLE || rx != ECHO_AA) end_op(1'b1);
                else begin
                    eng_retry = '0;
                    start_cmd(PH_C55_TX, 32'd0);
                end
            end
            PH_C58_TAIL:
                if (eng_idx < 3) begin
                    eng_idx = eng_idx + 10'd1;
                    tx(FILLER);
                end else end_op(eng_last != 8'h00);
            PH_RD_TOKEN:
                if (rx == DATA_TOKEN) begin
                    eng_phase = PH_RD_DATA;
                    eng_idx   = '0;
                    tx(FILLER);
                end else if (eng_poll >= lim_eff(20'(lim_token))) end_op(1'b1);
                else begin
                    eng_poll = eng_poll + 20'd1;
                    tx(FILLER);
                end
            PH_RD_DATA: begin
                nxt.rd_data  = rx;
                nxt.rd_valid = 1'b1;
                eng_idx = eng_idx + 10'd1;
                if (eng_idx >= SECTOR_BYTES) begin
                    eng_phase = PH_RD_CRC;
                    eng_idx   = '0;
                end
                tx(FILLER);
            end
            PH_RD_CRC:
                if (eng_idx == 0) begin
                    eng_idx = 10'd1;
                    tx(FILLER);
                end else end_op(1'b0);
            PH_WR_GAP: begin
                eng_phase = PH_WR_TOKEN;
                tx(DATA_TOKEN);
                nxt.need = 1'b1;
            end
            PH_WR_TOKEN: begin
                eng_idx = '0;
                sector_out(wd);
            end
            PH_WR_DATA: sector_out(wd);
            PH_WR_CRC: begin
                if (eng_idx == 0) eng_idx = 10'd1;
                else eng_phase = PH_WR_RESP;
                tx(FILLER);
            end
            PH_WR_RESP:
                if ((rx & DRESP_MASK) != DRESP_OK) end_op(1'b1);
                else begin
                    eng_phase = PH_WR_BUSY;
                    eng_poll  = 20'd1;
                    tx(FILLER);
                end
            PH_WR_BUSY:
                if (rx != 8'h00) end_op(1'b0);
                else if (eng_poll >= lim_eff(lim_busy)) end_op(1'b1);
                else begin
                    eng_poll = eng_poll + 20'd1;
                    tx(FILLER);
                end
            default: eng_phase = PH_IDLE;
        endcase
    endtask

    // next engine result for one item; advances the mirrored state
    task automatic engine_step(input logic [1:0] req, input logic [31:0] sec,
                               input logic [7:0] rx, input logic [7:0] wd,
                               output t_result r);
        nxt = '0;
        case (req)
            REQ_INIT:  start_cmd(PH_C0_TX, 32'd0);
            REQ_READ:  start_cmd(PH_C17_TX, sec);
            REQ_WRITE: start_cmd(PH_C24_TX, sec);
            default:   if (eng_phase != PH_IDLE) link_byte(rx, wd);
        endcase
        r = nxt;
        if (!r.tx_valid) r.tx_byte = '0;
        if (!r.rd_valid) r.rd_data = '0;
        if (!r.done)     r.status  = 1'b0;
    endtask

    // What a well-behaved card answers in the current phase, with some noise.
    function automatic logic [7:0] card_answer();
        if ($urandom_range(0, 99) < 4) return 8'($urandom);
        case (eng_phase)
            PH_C0_POLL, PH_C8_POLL, PH_C55_POLL, PH_C41_POLL, PH_C58_POLL, PH_C17_POLL,
            PH_C24_POLL: begin
                if ($urandom_range(0, 3) == 0) return FILLER;
                case (eng_phase)
                    PH_C0_POLL, PH_C8_POLL: return R1_IDLE;
                    PH_C55_POLL: return 8'($urandom_range(0, 1));
                    PH_C41_POLL: return ($urandom_range(0, 2) == 0) ? 8'h00 : R1_IDLE;
                    default: return 8'h00;
                endcase
            end
            PH_C8_TAIL:
                if (eng_idx == 2) return R1_IDLE;
                else if (eng_idx == 3) return ECHO_AA;
                else return 8'($urandom);
            PH_RD_TOKEN: return ($urandom_range(0, 2) == 0) ? DATA_TOKEN : FILLER;
            PH_WR_RESP: return {3'($urandom), DRESP_OK[4:0]};
            PH_WR_BUSY: return ($urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: random idle cycles, then hold the item until it is taken.
    // Stall is looked at on the falling edge, where it is settled.
    // ------------------------------------------------------------------
    task automatic offer_item(input logic [1:0] req, input logic [31:0] sec,
                              input logic [7:0] rx, input logic [7:0] wd,
                              input bit typed, input t_result typed_res);
        t_result r;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        engine_step(req, sec, rx, wd, r);
        expected_q.push_back(typed ? typed_res : r);
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_sector     <= sec;
        i_rx_byte    <= rx;
        i_write_data <= wd;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Limits are only touched with the engine drained and quiet.
    task automatic write_limit(input logic [1:0] idx, input logic [19:0] val);
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POLL:  lim_poll  = val[7:0];
            CFG_RETRY: lim_retry = val[15:0];
            CFG_TOKEN: lim_token = val[15:0];
            default:   lim_busy  = val;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: compare every taken result with the oldest expectation
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, tx %h", o_tx_byte);
            end else begin
                e = expected_q.pop_front();
                if (o_tx_byte !== e.tx_byte || o_tx_valid !== e.tx_valid ||
                    o_chip_select !== e.tx_valid || o_rd_data !== e.rd_data ||
                    o_rd_valid !== e.rd_valid || o_need_write_data !== e.need ||
                    o_done_res !== e.done || o_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d exp tx %h/%b rd %h/%b need %b done %b st %b",
                                 results_seen, e.tx_byte, e.tx_valid, e.rd_data,
                                 e.rd_valid, e.need, e.done, e.status,
                                 "  got tx %h/%b cs %b rd %h/%b need %b done %b st %b",
                                 o_tx_byte, o_tx_valid, o_chip_select, o_rd_data,
                                 o_rd_valid, o_need_write_data, o_done_res, o_status);
                end
            end
        end
    end

    // Receiver stall: random, plus one long hold-off so the input backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 900) begin
            i_stall   <= 1'b1;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows: typed expectations only where obvious
    // ------------------------------------------------------------------
    typedef struct {
        logic [1:0]  req;
        logic [31:0] sec;
        logic [7:0]  rx;
        logic [7:0]  wd;
        bit          typed;
        t_result     res;
    } t_row;

    localparam t_result NO_RES = '0;
    localparam t_result ERR_RES = '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1};

    t_row rows[] = '{
        // link while idle is dropped: all-zero result
        '{REQ_LINK, 32'h0, 8'hFF, 8'hFF, 1, NO_RES},
        // read at the top sector; bad R1 ends it in error
        '{REQ_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 1, '{8'h51, 1, 8'h00, 0, 0, 0, 0}},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h7F, 8'h00, 1, ERR_RES},
        // init, card answers CMD0 with 0x00 instead of idle
        '{REQ_INIT, 32'h0, 8'h00, 8'h00, 1, '{8'h40, 1, 8'h00, 0, 0, 0, 0}},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 1, ERR_RES},
        // write to sector zero, still polling for the CMD24 response, then cut short by init
        '{REQ_WRITE, 32'h0, 8'hFF, 8'hFF, 1, '{8'h58, 1, 8'h00, 0, 0, 0, 0}},
        '{REQ_LINK, 32'h0, 8'h80, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h80, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h80, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h80, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h80, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'h00, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'hFF, 0, NO_RES},
        '{REQ_LINK, 32'h0, 8'hFF, 8'h00, 0, NO_RES},
        '{REQ_INIT, 32'h0, 8'h00, 8'h00, 1, '{8'h40, 1, 8'h00, 0, 0, 0, 0}}
    };

    // limit sets per random pass: top, bottom, zero (acts as one) with a poll limit of 3
    logic [19:0] limit_sets[3][4] = '{
        '{20'd255, 20'd65535, 20'd65535, 20'hFFFFF},
        '{20'd1,   20'd1,     20'd1,     20'd1},
        '{20'd3,   20'd0,     20'd0,     20'd0}
    };

    initial begin
        int done_items;
        logic [1:0] req;
        int pick;
        lim_poll  = 8'd100;
        lim_retry = 16'd10000;
        lim_token = 16'd65535;
        lim_busy  = 20'hFFFFF;
        eng_phase = PH_IDLE;
        eng_idx   = '0;
        eng_poll  = '0;
        eng_retry = '0;
        eng_arg   = '0;
        eng_last  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            offer_item(rows[k].req, rows[k].sec, rows[k].rx, rows[k].wd,
                       rows[k].typed, rows[k].res);

        // three random passes: receiver-heavy stalling, sender-heavy idling, none
        for (int p = 0; p < 3; p++) begin
            snd_idle_pct = (p == 0) ? 28 : (p == 1) ? 75 : 0;
            rcv_idle_pct = (p == 0) ? 75 : (p == 1) ? 28 : 0;
            for (int k = 0; k < 4; k++) write_limit(2'(k), limit_sets[p][k]);
            done_items = 0;
            while (done_items < ITEMS_PER_PH) begin
                if (eng_phase == PH_IDLE || $urandom_range(0, 199) == 0) begin
                    pick = $urandom_range(0, 19);
                    req = (pick < 1) ? REQ_LINK : (pick < 12) ? REQ_INIT :
                          (pick < 16) ? REQ_READ : REQ_WRITE;
                    if (!(req == REQ_LINK && eng_phase == PH_IDLE)) done_items++;
                    offer_item(req, $urandom, 8'($urandom), 8'($urandom), 0, NO_RES);
                end else begin
                    done_items++;
                    offer_item(REQ_LINK, $urandom, card_answer(), 8'($urandom), 0, NO_RES);
                end
            end
        end
        i_valid <= 1'b0;

        wait (expected_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
